>>> sv/ccs_pkg.sv
`default_nettype none

package ccs_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // sample coordinates are formed at 2^-(F+EXTRA_BITS) before rounding
  localparam int EXTRA_BITS = 17;

  // 2 * 0.66 in units of 2^-16 (0.66 = 43254 / 65536)
  localparam int                      OFFSET_KW = 18;
  localparam logic signed [OFFSET_KW-1:0] OFFSET_K2 = 18'sd86508;

  localparam logic [15:0] W_CORNER = 16'd3277;
  localparam logic [15:0] W_EDGE   = 16'd9830;
  localparam logic [15:0] W_CENTRE = 16'd13107;

  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_U   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_V   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_U    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_V    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLE_SQ   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_TINT_RED  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TINT_GRN  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_TINT_BLUE = 3'd7;

  // weight of sample (iu, iv); index 1 is the center tap on each axis
  function automatic logic [15:0] sample_weight(input logic [1:0] iu, input logic [1:0] iv);
    logic off_u;
    logic off_v;
    off_u = (iu != 2'd1);
    off_v = (iv != 2'd1);
    if (off_u && off_v) begin
      sample_weight = W_CORNER;
    end else if (off_u || off_v) begin
      sample_weight = W_EDGE;
    end else begin
      sample_weight = W_CENTRE;
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/circle_coverage_shader.sv
`default_nettype none

// Anti-aliased ring coverage, 3x3 supersampling per pixel.
// Input: pulse start with in_column / in_row; the item is taken when start is
// high and busy is low. busy is high only for the first cycle out of reset,
// after that one item is taken every clock in which start is high.
// Output: out_valid marks each result for one cycle; the pixel position comes
// back with coverage and the tint scaled by it. The receiver cannot stall.
// Throughput is one item per clock; out_valid comes from the last stage.
// Seven register stages, the first loaded at the accepting edge:
// coordinate multiply, coordinate add and round, square, radius compare,
// coverage sum, tint multiply, divide-by-65535 fold.
// Configuration: cfg_we writes cfg_data into register cfg_index in the same
// cycle; write only while no item is in flight.
// Reset (rst_n low, synchronous) clears the configuration and valid registers
// and drops every item in flight.
module circle_coverage_shader import ccs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int CFG_W     = (FRAC_BITS + 4 > 16) ? FRAC_BITS + 4 : 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [COORD_BITS-1:0]   in_column,
  input  logic [COORD_BITS-1:0]   in_row,
  output logic                    out_valid,
  output logic [COORD_BITS-1:0]   out_column,
  output logic [COORD_BITS-1:0]   out_row,
  output logic [15:0]             out_coverage,
  output logic [15:0]             out_shade_red,
  output logic [15:0]             out_shade_green,
  output logic [15:0]             out_shade_blue,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int UVW  = FRAC_BITS + 4;
  localparam int SQW  = 2 * FRAC_BITS + 4;
  localparam int D2W  = SQW + 1;
  localparam int NSTG = 7;

  localparam logic [D2W-1:0] ONE_SQ = D2W'(1) << (2 * FRAC_BITS);

  logic signed [UVW-1:0]   start_u_r, start_v_r, step_u_r, step_v_r;
  logic        [FRAC_BITS:0] hole_r;
  logic        [15:0]      tint_red_r, tint_green_r, tint_blue_r;

  logic                    busy_r;
  logic                    accept;
  logic [NSTG-1:0]         v_r;
  logic [COORD_BITS-1:0]   col_r [NSTG];
  logic [COORD_BITS-1:0]   row_r [NSTG];

  logic [2:0][SQW-1:0]     sq_u, sq_v;
  logic [2:0]              ok_u, ok_v;
  logic [D2W-1:0]          hole_lim;
  logic [8:0]              hit_nxt, hit_r;
  logic [15:0]             cov_nxt, cov_r, cov6_r, cov7_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_u_r    <= '0;
      start_v_r    <= '0;
      step_u_r     <= '0;
      step_v_r     <= '0;
      hole_r       <= '0;
      tint_red_r   <= '0;
      tint_green_r <= '0;
      tint_blue_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_U:   start_u_r    <= cfg_data[UVW-1:0];
        REG_START_V:   start_v_r    <= cfg_data[UVW-1:0];
        REG_STEP_U:    step_u_r     <= cfg_data[UVW-1:0];
        REG_STEP_V:    step_v_r     <= cfg_data[UVW-1:0];
        REG_HOLE_SQ:   hole_r       <= cfg_data[FRAC_BITS:0];
        REG_TINT_RED:  tint_red_r   <= cfg_data[15:0];
        REG_TINT_GRN:  tint_green_r <= cfg_data[15:0];
        REG_TINT_BLUE: tint_blue_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake and valid pipe ----------------
  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      v_r    <= '0;
    end else begin
      busy_r <= 1'b0;
      v_r    <= {v_r[NSTG-2:0], accept};
    end
  end

  // pixel position rides alongside
  always_ff @(posedge clk) begin
    col_r[0] <= in_column;
    row_r[0] <= in_row;
    for (int s = 1; s < NSTG; s++) begin
      col_r[s] <= col_r[s-1];
      row_r[s] <= row_r[s-1];
    end
  end

  // ---------------- stages 1-3: sample coordinates and squares ----------------
  ccs_axis #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_u (
    .clk    (clk),
    .start_c(start_u_r),
    .step_c (step_u_r),
    .idx    (in_column),
    .sq_o   (sq_u),
    .ok_o   (ok_u)
  );

  ccs_axis #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_v (
    .clk    (clk),
    .start_c(start_v_r),
    .step_c (step_v_r),
    .idx    (in_row),
    .sq_o   (sq_v),
    .ok_o   (ok_v)
  );

  // ---------------- stage 4: ring test on nine samples ----------------
  assign hole_lim = D2W'({hole_r, {FRAC_BITS{1'b0}}});

  always_comb begin
    for (int iv = 0; iv < 3; iv++) begin
      for (int iu = 0; iu < 3; iu++) begin
        logic [D2W-1:0] d2;
        d2 = {1'b0, sq_u[iu]} + {1'b0, sq_v[iv]};
        hit_nxt[iv*3+iu] = ok_u[iu] && ok_v[iv] && (hole_lim <= d2) && (d2 <= ONE_SQ);
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

  // ---------------- stage 5: weighted coverage ----------------
  // nine hits sum to exactly 65535, no saturation needed
  always_comb begin
    cov_nxt = '0;
    for (int k = 0; k < 9; k++) begin
      if (hit_r[k]) begin
        cov_nxt = cov_nxt + sample_weight(2'(k % 3), 2'(k / 3));
      end
    end
  end

  always_ff @(posedge clk) begin
    cov_r  <= cov_nxt;
    cov6_r <= cov_r;
    cov7_r <= cov6_r;
  end

  // ---------------- stages 6-7: tint scaling ----------------
  ccs_shade u_shade_red (
    .clk  (clk),
    .tint (tint_red_r),
    .cov  (cov_r),
    .shade(out_shade_red)
  );

  ccs_shade u_shade_green (
    .clk  (clk),
    .tint (tint_green_r),
    .cov  (cov_r),
    .shade(out_shade_green)
  );

  ccs_shade u_shade_blue (
    .clk  (clk),
    .tint (tint_blue_r),
    .cov  (cov_r),
    .shade(out_shade_blue)
  );

  assign out_valid    = v_r[NSTG-1];
  assign out_column   = col_r[NSTG-1];
  assign out_row      = row_r[NSTG-1];
  assign out_coverage = cov7_r;

  // ---------------- assertions ----------------
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v_r[0])
    else $error("accepted item did not enter the pipeline");

  a_shade_le_tint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_shade_red <= $past(tint_red_r, 2)) &&
                  (out_shade_green <= $past(tint_green_r, 2)) &&
                  (out_shade_blue <= $past(tint_blue_r, 2)))
    else $error("shade exceeds tint");

  a_full_cov: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coverage == 16'hFFFF) |->
      (out_shade_red == $past(tint_red_r, 2)) &&
      (out_shade_green == $past(tint_green_r, 2)) &&
      (out_shade_blue == $past(tint_blue_r, 2)))
    else $error("full coverage does not pass tint through");

  a_zero_cov: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coverage == 16'd0) |->
      (out_shade_red == 16'd0) && (out_shade_green == 16'd0) && (out_shade_blue == 16'd0))
    else $error("zero coverage gives nonzero shade");

endmodule

`default_nettype wire

>>> sv/ccs_axis.sv
`default_nettype none

// One axis: three sample coordinates (-0.66, 0, +0.66 step) and their squares.
// Three register stages: products, rounded coordinates, squares.
module ccs_axis import ccs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic signed [FRAC_BITS+3:0]        start_c,
  input  logic signed [FRAC_BITS+3:0]        step_c,
  input  logic        [COORD_BITS-1:0]       idx,
  output logic        [2:0][2*FRAC_BITS+3:0] sq_o,
  output logic        [2:0]                  ok_o
);

  localparam int UVW  = FRAC_BITS + 4;
  localparam int AW   = COORD_BITS + UVW + 2;
  localparam int BW   = OFFSET_KW + UVW;
  localparam int EXTW = COORD_BITS + FRAC_BITS + 24;
  localparam int CW   = EXTW - EXTRA_BITS;
  localparam int MW   = FRAC_BITS + 2;
  localparam int SQW  = 2 * MW;

  localparam logic signed [CW-1:0] LIM = CW'(2) <<< FRAC_BITS;

  logic signed [AW-1:0]   a_nxt, a_r;
  logic signed [BW-1:0]   b_nxt, b_r;
  logic signed [EXTW-1:0] ext0;
  logic signed [EXTW-1:0] ext [3];
  logic signed [CW-1:0]   coord [3];
  logic        [MW-1:0]   mag_nxt [3];
  logic        [MW-1:0]   mag_r [3];
  logic        [2:0]      ok_nxt, ok_b_r, ok_c_r;
  logic        [SQW-1:0]  sq_r [3];

  // (2*idx + 1) * step and 2*K*step
  always_comb begin
    a_nxt = $signed({1'b0, idx, 1'b1}) * step_c;
    b_nxt = OFFSET_K2 * step_c;
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  // exact sum, half added, then floor shift
  always_comb begin
    ext0 = (EXTW'(start_c) <<< EXTRA_BITS) + (EXTW'(a_r) <<< (EXTRA_BITS - 1))
         + (EXTW'(1) <<< (EXTRA_BITS - 1));
    ext[0] = ext0 - EXTW'(b_r);
    ext[1] = ext0;
    ext[2] = ext0 + EXTW'(b_r);
    for (int i = 0; i < 3; i++) begin
      coord[i]   = ext[i][EXTW-1:EXTRA_BITS];
      ok_nxt[i]  = (coord[i] <= LIM) && (coord[i] >= -LIM);
      mag_nxt[i] = coord[i][CW-1] ? MW'(-coord[i]) : MW'(coord[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag_r[i] <= mag_nxt[i];
      sq_r[i]  <= mag_r[i] * mag_r[i];
    end
    ok_b_r <= ok_nxt;
    ok_c_r <= ok_b_r;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_o[i] = sq_r[i];
    end
  end

  assign ok_o = ok_c_r;

endmodule

`default_nettype wire

>>> sv/ccs_shade.sv
`default_nettype none

// tint * coverage / 65535, rounded; two register stages.
// x / 65535 == (x + (x >> 16) + 1) >> 16 for every x below 2^32 - 1.
module ccs_shade import ccs_pkg::*; (
  input  logic        clk,
  input  logic [15:0] tint,
  input  logic [15:0] cov,
  output logic [15:0] shade
);

  logic [31:0] prod_r;
  logic [31:0] x;
  logic [32:0] fold;
  logic [15:0] shade_r;

  always_ff @(posedge clk) begin
    prod_r <= tint * cov;
  end

  always_comb begin
    x    = prod_r + 32'd32767;
    fold = {1'b0, x} + {17'd0, x[31:16]} + 33'd1;
  end

  always_ff @(posedge clk) begin
    shade_r <= fold[31:16];
  end

  assign shade = shade_r;

endmodule

`default_nettype wire

>>> sim/tb_circle_coverage_shader.sv
`timescale 1ns / 1ps

module tb_circle_coverage_shader;
  import ccs_pkg::*;

  localparam int     PIPE_LAT    = 7;
  localparam int     CYCLE_LIMIT = 200000;
  localparam longint FAR_LIM     = 131072;          // 2.0 in Q.16
  localparam longint UNIT_SQ     = 64'sd1 <<< 32;   // 1.0 in Q.32

  localparam logic [0:7][2:0] REG_ORDER = {REG_START_U, REG_START_V, REG_STEP_U, REG_STEP_V,
                                           REG_HOLE_SQ, REG_TINT_RED, REG_TINT_GRN,
                                           REG_TINT_BLUE};
  localparam logic [0:4][19:0] EDGE_VALS = {20'h80000, 20'h7FFFF, 20'h00000, 20'hFFFFF,
                                            20'h00001};
  localparam logic [0:3][19:0] HOLE_VALS = {20'h00000, 20'h10000, 20'h10001, 20'hFFFFF};
  localparam logic [0:2][19:0] TINT_VALS = {20'h00000, 20'h0FFFF, 20'hFFFFF};

  // register values in index order
  typedef logic [0:7][19:0] setting_t;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] cov;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pixel_t;

  typedef struct {
    int          cfg;
    logic [11:0] col;
    logic [11:0] row;
    bit          typed;
    logic [15:0] cov;
    logic [15:0] shade;
  } probe_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] in_column = '0;
  logic [11:0] in_row = '0;
  logic        out_valid;
  logic [11:0] out_column;
  logic [11:0] out_row;
  logic [15:0] out_coverage;
  logic [15:0] out_shade_red;
  logic [15:0] out_shade_green;
  logic [15:0] out_shade_blue;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // typed-in expectation that travels with the item being offered
  logic        typed_on = 1'b0;
  logic [15:0] typed_cov = '0;
  logic [15:0] typed_shade = '0;

  // mirror of the block's registers
  logic signed [19:0] m_start_u = '0;
  logic signed [19:0] m_start_v = '0;
  logic signed [19:0] m_step_u = '0;
  logic signed [19:0] m_step_v = '0;
  logic [16:0]        m_hole = '0;
  logic [15:0]        m_red = '0;
  logic [15:0]        m_green = '0;
  logic [15:0]        m_blue = '0;

  pixel_t   pending_pixels[$];
  pixel_t   want_px;
  pixel_t   got_px;
  setting_t dir_cfg [1:8];
  probe_t   probes[$];
  int       errors = 0;
  int       cycles = 0;

  circle_coverage_shader u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_column      (in_column),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_coverage   (out_coverage),
    .out_shade_red  (out_shade_red),
    .out_shade_green(out_shade_green),
    .out_shade_blue (out_shade_blue),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // sample position in Q.16, m selects the -0.66 / 0 / +0.66 tap
  function automatic longint tap_position(longint origin, longint pitch, longint idx,
                                          longint m);
    longint fine;
    fine = origin * 131072 + (2 * idx + 1) * pitch * 65536 + m * longint'(OFFSET_K2) * pitch;
    return (fine + 65536) >>> 17;
  endfunction

  function automatic pixel_t shade_pixel(logic [11:0] col, logic [11:0] row);
    pixel_t res;
    longint pu [3];
    longint pv [3];
    longint d2;
    int     cov;
    int     ku;
    int     kv;
    cov = 0;
    for (ku = 0; ku < 3; ku++) begin
      pu[ku] = tap_position(m_start_u, m_step_u, col, ku - 1);
      pv[ku] = tap_position(m_start_v, m_step_v, row, ku - 1);
    end
    for (kv = 0; kv < 3; kv++) begin
      for (ku = 0; ku < 3; ku++) begin
        if (pu[ku] <= FAR_LIM && pu[ku] >= -FAR_LIM &&
            pv[kv] <= FAR_LIM && pv[kv] >= -FAR_LIM) begin
          d2 = pu[ku] * pu[ku] + pv[kv] * pv[kv];
          if (d2 >= (longint'(m_hole) <<< 16) && d2 <= UNIT_SQ) begin
            if (ku != 1 && kv != 1) cov += W_CORNER;
            else if (ku != 1 || kv != 1) cov += W_EDGE;
            else cov += W_CENTRE;
          end
        end
      end
    end
    if (cov > 65535) cov = 65535;
    res.col   = col;
    res.row   = row;
    res.cov   = 16'(cov);
    res.red   = 16'((longint'(m_red) * cov + 32767) / 65535);
    res.green = 16'((longint'(m_green) * cov + 32767) / 65535);
    res.blue  = 16'((longint'(m_blue) * cov + 32767) / 65535);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_START_U:   m_start_u = cfg_data;
        REG_START_V:   m_start_v = cfg_data;
        REG_STEP_U:    m_step_u = cfg_data;
        REG_STEP_V:    m_step_v = cfg_data;
        REG_HOLE_SQ:   m_hole = cfg_data[16:0];
        REG_TINT_RED:  m_red = cfg_data[15:0];
        REG_TINT_GRN:  m_green = cfg_data[15:0];
        REG_TINT_BLUE: m_blue = cfg_data[15:0];
        default: ;
      endcase
    end
    if (rst_n && out_valid) begin
      got_px = '{out_column, out_row, out_coverage, out_shade_red, out_shade_green,
                 out_shade_blue};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got col %0d row %0d", $time,
                 out_column, out_row);
        errors++;
      end else begin
        want_px = pending_pixels.pop_front();
        check_field("column", 16'(want_px.col), 16'(got_px.col));
        check_field("row", 16'(want_px.row), 16'(got_px.row));
        check_field("coverage", want_px.cov, got_px.cov);
        check_field("shade_red", want_px.red, got_px.red);
        check_field("shade_green", want_px.green, got_px.green);
        check_field("shade_blue", want_px.blue, got_px.blue);
      end
    end
    if (rst_n && start && busy === 1'b0) begin
      want_px = shade_pixel(in_column, in_row);
      if (typed_on) begin
        want_px.cov   = typed_cov;
        want_px.red   = typed_shade;
        want_px.green = typed_shade;
        want_px.blue  = typed_shade;
      end
      pending_pixels.push_back(want_px);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic drive_pixel(input logic [11:0] col, input logic [11:0] row, input bit typed,
                             input logic [15:0] cov, input logic [15:0] shade);
    start       <= 1'b1;
    in_column   <= col;
    in_row      <= row;
    typed_on    <= typed;
    typed_cov   <= cov;
    typed_shade <= shade;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // mostly back to back, some short pauses, a few long ones; none when quiet
  task automatic idle_gap(input bit quiet);
    int n;
    int pick;
    n = 0;
    pick = $urandom_range(0, 9);
    if (!quiet && pick >= 6) n = (pick == 9) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    if (n > 0) begin
      start     <= 1'b0;
      in_column <= 12'($urandom);
      in_row    <= 12'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_pixels.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic load_setting(input setting_t vals);
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    setting_t s;
    int       cur_cfg;
    int       phase;
    int       item;
    int       ax;
    int       mode;
    int       span;
    int       pitch;
    int       origin;
    int       axis_n [2];
    bit       noisy;

    // start_u, start_v, step_u, step_v, hole, red, green, blue
    dir_cfg[1] = '{20'h0, 20'h0, 20'h0, 20'h0, 20'h0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF};
    dir_cfg[2] = '{20'h10000, 20'h0, 20'h0, 20'h0, 20'hFFFFF, 20'hFFFF, 20'hFFFF, 20'hFFFF};
    dir_cfg[3] = '{20'h80000, 20'h0, 20'h0, 20'h0, 20'h0, 20'hFFFF, 20'hFFFF, 20'hFFFF};
    dir_cfg[4] = '{20'h7FFFF, 20'h7FFFF, 20'h0, 20'h0, 20'h0, 20'hFFFF, 20'hFFFF, 20'hFFFF};
    dir_cfg[5] = '{20'h10000, 20'h0, 20'h0, 20'h0, 20'h10000, 20'hFFFF, 20'hFFFF, 20'hFFFF};
    dir_cfg[6] = '{20'hF0000, 20'hF0000, 20'h00800, 20'h00800, 20'h04000, 20'hFFFF,
                   20'h08000, 20'h00001};
    dir_cfg[7] = '{20'h0, 20'h0, 20'h7FFFF, 20'h80000, 20'h0, 20'h03039, 20'h0, 20'hFFFFF};
    dir_cfg[8] = '{20'h10000, 20'h0, 20'hFFF00, 20'h00001, 20'h0FFF0, 20'h09C40, 20'h04E20,
                   20'h00064};

    // registers at reset: all samples at the origin, full coverage, black
    probes.push_back('{0, 12'd0, 12'd0, 1'b1, 16'd65535, 16'd0});
    probes.push_back('{0, 12'd4095, 12'd4095, 1'b1, 16'd65535, 16'd0});
    probes.push_back('{0, 12'hAAA, 12'h555, 1'b1, 16'd65535, 16'd0});
    // zero step, tints written wide
    probes.push_back('{1, 12'd0, 12'd0, 1'b1, 16'd65535, 16'd65535});
    probes.push_back('{1, 12'd2048, 12'd1, 1'b1, 16'd65535, 16'd65535});
    // hole above one
    probes.push_back('{2, 12'd0, 12'd0, 1'b1, 16'd0, 16'd0});
    probes.push_back('{2, 12'd100, 12'd200, 1'b1, 16'd0, 16'd0});
    // far samples
    probes.push_back('{3, 12'd0, 12'd0, 1'b1, 16'd0, 16'd0});
    probes.push_back('{3, 12'd4095, 12'd0, 1'b1, 16'd0, 16'd0});
    probes.push_back('{4, 12'd7, 12'd7, 1'b1, 16'd0, 16'd0});
    // exactly on the unit circle with hole of 1.0: both bounds inclusive
    probes.push_back('{5, 12'd0, 12'd0, 1'b1, 16'd65535, 16'd65535});
    probes.push_back('{5, 12'd4095, 12'd4095, 1'b1, 16'd65535, 16'd65535});
    // ring over a 64x64 region
    probes.push_back('{6, 12'd0, 12'd0, 1'b0, 16'd0, 16'd0});
    probes.push_back('{6, 12'd31, 12'd0, 1'b0, 16'd0, 16'd0});
    probes.push_back('{6, 12'd63, 12'd31, 1'b0, 16'd0, 16'd0});
    probes.push_back('{6, 12'd31, 12'd31, 1'b0, 16'd0, 16'd0});
    probes.push_back('{6, 12'd20, 12'd20, 1'b0, 16'd0, 16'd0});
    probes.push_back('{6, 12'd45, 12'd50, 1'b0, 16'd0, 16'd0});
    probes.push_back('{6, 12'd4095, 12'd4095, 1'b0, 16'd0, 16'd0});
    // largest steps
    probes.push_back('{7, 12'd0, 12'd0, 1'b0, 16'd0, 16'd0});
    probes.push_back('{7, 12'd4095, 12'd4095, 1'b0, 16'd0, 16'd0});
    probes.push_back('{7, 12'd0, 12'd4095, 1'b0, 16'd0, 16'd0});
    // small negative step, thin ring near the rim
    probes.push_back('{8, 12'd0, 12'd0, 1'b0, 16'd0, 16'd0});
    probes.push_back('{8, 12'd255, 12'd0, 1'b0, 16'd0, 16'd0});
    probes.push_back('{8, 12'd128, 12'd7, 1'b0, 16'd0, 16'd0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    cur_cfg = 0;
    foreach (probes[i]) begin
      if (probes[i].cfg != cur_cfg) begin
        settle();
        load_setting(dir_cfg[probes[i].cfg]);
        cur_cfg = probes[i].cfg;
      end
      drive_pixel(probes[i].col, probes[i].row, probes[i].typed, probes[i].cov,
                  probes[i].shade);
      idle_gap(1'b0);
    end

    for (phase = 0; phase < 10; phase++) begin
      settle();
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        // region framed around the unit circle, scanned in either direction
        for (ax = 0; ax < 2; ax++) begin
          axis_n[ax] = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                                   : $urandom_range(3, 40);
          span   = 131072 + int'($urandom_range(0, 40000));
          pitch  = span / axis_n[ax];
          origin = -(span / 2) + int'($urandom_range(0, 6000)) - 3000;
          if ($urandom_range(0, 1) == 1) begin
            origin = -origin;
            pitch  = -pitch;
          end
          s[ax]     = 20'(origin);
          s[ax + 2] = 20'(pitch);
        end
        case ($urandom_range(0, 3))
          0: s[4] = 20'h0;
          1: s[4] = 20'($urandom_range(0, 65536));
          2: s[4] = 20'($urandom_range(0, 20000));
          default: s[4] = 20'($urandom);
        endcase
        for (ax = 5; ax < 8; ax++)
          s[ax] = ($urandom_range(0, 2) == 0) ? TINT_VALS[$urandom_range(0, 2)]
                                              : 20'($urandom);
      end else if (mode <= 7) begin
        for (ax = 0; ax < 8; ax++) s[ax] = 20'($urandom);
        axis_n = '{4096, 4096};
      end else begin
        for (ax = 0; ax < 4; ax++) s[ax] = EDGE_VALS[$urandom_range(0, 4)];
        s[4] = HOLE_VALS[$urandom_range(0, 3)];
        for (ax = 5; ax < 8; ax++) s[ax] = TINT_VALS[$urandom_range(0, 2)];
        axis_n = '{4096, 4096};
      end
      load_setting(s);
      for (item = 0; item < 90; item++) begin
        noisy = ($urandom_range(0, 6) == 0);
        drive_pixel(noisy ? 12'($urandom) : 12'($urandom_range(0, axis_n[0] - 1)),
                    noisy ? 12'($urandom) : 12'($urandom_range(0, axis_n[1] - 1)),
                    1'b0, 16'd0, 16'd0);
        idle_gap(phase % 3 == 0);
      end
    end

    settle();
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never came out", $time, pending_pixels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ccs_pkg.sv
sv/ccs_axis.sv
sv/ccs_shade.sv
sv/circle_coverage_shader.sv
sim/tb_circle_coverage_shader.sv
